@@ src/aes_ke_pkg.sv @@
package aes_ke_pkg;

  localparam int unsigned NumWords = 44;
  localparam logic [5:0]  LastIdx  = 6'(NumWords - 1);
  localparam logic [7:0]  RconStart = 8'h01;
  localparam logic [7:0]  GfReduce  = 8'h1b;
  localparam logic [2:0]  SubSteps  = 3'd4;

  localparam logic ActWrite  = 1'b0;
  localparam logic ActExpand = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StKey,
    StSub,
    StGen
  } state_e;

  typedef struct packed {
    logic       load;
    logic       emit_key;
    logic       gen;
    logic       use_sub;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap;
    logic [5:0] idx;
    logic       last;
  } ctrl_t;

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    logic [7:0] r;
    r = {v[6:0], 1'b0};
    if (v[7]) begin
      r = r ^ GfReduce;
    end
    return r;
  endfunction

endpackage

@@ src/aes128_key_expansion_unit.sv @@
// AES-128 key schedule with a loadable S-box. An item with action 0 writes
// one S-box entry in the cycle it is accepted; busy_o stays low, so items may
// follow back to back. An item with action 1 holds busy_o high while the
// four key words go out and through 10 rounds; each round the S-box, with
// its single read port, looks up the four bytes of the rotated word one at
// a time, then the round's four words go out. Words w[0]..w[43] come out
// in order, each marked by word_valid_o, with a gap for the S-box lookup
// before every fourth word from w[4] on; last_word_o marks w[43]. Results
// cannot be stalled: the receiver must take each one in the cycle word_valid_o
// is high. Every S-box entry must be written before a key item is given.
module aes128_key_expansion_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [7:0]  sbox_index_i,
  input  logic [7:0]  sbox_value_i,
  input  logic [63:0] key_high_i,
  input  logic [63:0] key_low_i,
  output logic        word_valid_o,
  output logic [5:0]  word_index_o,
  output logic [31:0] round_word_o,
  output logic        last_word_o
);

  aes_ke_pkg::ctrl_t ctrl;
  logic [31:0] win_q [4];
  logic [31:0] sub_q;
  logic [7:0]  rcon_q;
  logic [7:0]  rd_addr;
  logic [7:0]  rd_data;
  logic        tbl_we;
  logic [31:0] temp;
  logic [31:0] new_word;
  logic        valid_q;
  logic [5:0]  index_q;
  logic [31:0] word_q;
  logic        last_q;

  assign tbl_we = start_i && !busy_o && (action_i == aes_ke_pkg::ActWrite);

  aes_ke_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .action_i(action_i),
    .busy_o  (busy_o),
    .ctrl_o  (ctrl)
  );

  // rotated word bytes, top first
  always_comb begin
    case (ctrl.rd_sel)
      2'd0:    rd_addr = win_q[3][23:16];
      2'd1:    rd_addr = win_q[3][15:8];
      2'd2:    rd_addr = win_q[3][7:0];
      default: rd_addr = win_q[3][31:24];
    endcase
  end

  aes_ke_sbox u_sbox (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(sbox_index_i),
    .wdata_i(sbox_value_i),
    .re_i   (ctrl.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign temp     = ctrl.use_sub ? (sub_q ^ {rcon_q, 24'h000000}) : win_q[3];
  assign new_word = win_q[0] ^ temp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= 32'h0;
      win_q[1] <= 32'h0;
      win_q[2] <= 32'h0;
      win_q[3] <= 32'h0;
      rcon_q   <= aes_ke_pkg::RconStart;
    end else begin
      if (ctrl.load) begin
        win_q[0] <= key_high_i[63:32];
        win_q[1] <= key_high_i[31:0];
        win_q[2] <= key_low_i[63:32];
        win_q[3] <= key_low_i[31:0];
        rcon_q   <= aes_ke_pkg::RconStart;
      end else if (ctrl.emit_key) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= win_q[3];
        win_q[3] <= win_q[0];
      end else if (ctrl.gen) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= win_q[3];
        win_q[3] <= new_word;
        if (ctrl.use_sub) begin
          rcon_q <= aes_ke_pkg::gf_double(rcon_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.cap) begin
      sub_q <= {sub_q[23:0], rd_data};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl.emit_key || ctrl.gen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit_key || ctrl.gen) begin
      index_q <= ctrl.idx;
      word_q  <= ctrl.emit_key ? win_q[0] : new_word;
      last_q  <= ctrl.last;
    end
  end

  assign word_valid_o = valid_q;
  assign word_index_o = index_q;
  assign round_word_o = word_q;
  assign last_word_o  = valid_q && last_q;

  property p_last_index;
    @(posedge clk_i) disable iff (!rst_ni)
      last_word_o |-> (word_index_o == aes_ke_pkg::LastIdx);
  endproperty
  a_last_index: assert property (p_last_index)
    else $error("last word flagged at wrong index");

  property p_first_after_key;
    @(posedge clk_i) disable iff (!rst_ni)
      (word_valid_o && word_index_o == 6'd0) |->
        $past(start_i && !busy_o && action_i == aes_ke_pkg::ActExpand, 2);
  endproperty
  a_first_after_key: assert property (p_first_after_key)
    else $error("word 0 without a key item");

  property p_index_step;
    @(posedge clk_i) disable iff (!rst_ni)
      (word_valid_o && word_index_o[1:0] != 2'd0) |->
        ($past(word_valid_o) && $past(word_index_o) == word_index_o - 6'd1);
  endproperty
  a_index_step: assert property (p_index_step)
    else $error("word index out of sequence");

endmodule

@@ src/aes_ke_sbox.sv @@
module aes_ke_sbox (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic       re_i,
  input  logic [7:0] raddr_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [256];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/aes_ke_fsm.sv @@
module aes_ke_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              action_i,
  output logic              busy_o,
  output aes_ke_pkg::ctrl_t ctrl_o
);

  aes_ke_pkg::state_e state_q, state_d;
  logic [5:0] word_cnt_q, word_cnt_d;
  logic [2:0] sub_cnt_q, sub_cnt_d;

  always_comb begin
    state_d    = state_q;
    word_cnt_d = word_cnt_q;
    sub_cnt_d  = 3'd0;
    unique case (state_q)
      aes_ke_pkg::StIdle: begin
        word_cnt_d = 6'd0;
        if (start_i && action_i == aes_ke_pkg::ActExpand) begin
          state_d = aes_ke_pkg::StKey;
        end
      end
      aes_ke_pkg::StKey: begin
        word_cnt_d = word_cnt_q + 6'd1;
        if (word_cnt_q[1:0] == 2'd3) begin
          state_d = aes_ke_pkg::StSub;
        end
      end
      aes_ke_pkg::StSub: begin
        sub_cnt_d = sub_cnt_q + 3'd1;
        if (sub_cnt_q == aes_ke_pkg::SubSteps) begin
          sub_cnt_d = 3'd0;
          state_d   = aes_ke_pkg::StGen;
        end
      end
      aes_ke_pkg::StGen: begin
        word_cnt_d = word_cnt_q + 6'd1;
        if (word_cnt_q == aes_ke_pkg::LastIdx) begin
          state_d = aes_ke_pkg::StIdle;
        end else if (word_cnt_q[1:0] == 2'd3) begin
          state_d = aes_ke_pkg::StSub;
        end
      end
      default: begin
        state_d = aes_ke_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.idx      = word_cnt_q;
    ctrl_o.last     = (word_cnt_q == aes_ke_pkg::LastIdx);
    ctrl_o.rd_sel   = sub_cnt_q[1:0];
    unique case (state_q)
      aes_ke_pkg::StIdle: begin
        ctrl_o.load = start_i && (action_i == aes_ke_pkg::ActExpand);
      end
      aes_ke_pkg::StKey: begin
        ctrl_o.emit_key = 1'b1;
      end
      aes_ke_pkg::StSub: begin
        ctrl_o.rd_en = (sub_cnt_q != aes_ke_pkg::SubSteps);
        ctrl_o.cap   = (sub_cnt_q != 3'd0);
      end
      aes_ke_pkg::StGen: begin
        ctrl_o.gen     = 1'b1;
        ctrl_o.use_sub = (word_cnt_q[1:0] == 2'd0);
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= aes_ke_pkg::StIdle;
      word_cnt_q <= 6'd0;
      sub_cnt_q  <= 3'd0;
    end else begin
      state_q    <= state_d;
      word_cnt_q <= word_cnt_d;
      sub_cnt_q  <= sub_cnt_d;
    end
  end

  assign busy_o = (state_q != aes_ke_pkg::StIdle);

endmodule
